/* src/obb_pkg.sv */
// shared constants for the oriented box overlap test
// no dependencies
package obb_pkg;
	localparam int COMPONENT_BITS = 21;
	localparam int FIELD_W        = 63;
	localparam int QUEUE_PTR_W    = 1;
	localparam int QUEUE_DEPTH    = 2 ** QUEUE_PTR_W;
endpackage

/* src/oriented_box_overlap_test.sv */
// top level of the oriented box overlap test
// depends on obb_pkg, obb_front, obb_queue, obb_back
//
// separating-axis test of two oriented boxes on 15 axes. a request is taken
// on a clock edge with start high and busy low; one request can be taken
// every cycle while busy stays low. the result appears on overlap with done
// high for exactly one cycle, once the request has passed the front stage
// register, the queue and the five back pipeline stages (component products,
// dot products, split partial products, full products, axis sums) and the
// compare register, which drives overlap; a valid shift register drives done.
// the receiver cannot stall, so the back pipeline never stops and busy only
// rises if the two-entry queue were full. overlap is 1 when no axis
// separates the boxes (touching boxes count as overlapping), 0 otherwise.
// each 63-bit field holds x, y, z as signed COMPONENT_BITS-wide components
// from bit 0 upward; higher bits are ignored
module oriented_box_overlap_test #(
	parameter int COMPONENT_BITS = obb_pkg::COMPONENT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [obb_pkg::FIELD_W-1:0] a_centre,
	input  logic [obb_pkg::FIELD_W-1:0] a_extent,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_x,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_y,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_z,
	input  logic [obb_pkg::FIELD_W-1:0] b_centre,
	input  logic [obb_pkg::FIELD_W-1:0] b_extent,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_x,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_y,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_z,
	output logic                        done,
	output logic                        overlap
);
	// offset, two extents, two sets of axes
	localparam int ITEM_W = 27 * COMPONENT_BITS + 3;

	logic              q_full;
	logic              push;
	logic [ITEM_W-1:0] push_data;
	logic              rd_vld;
	logic [ITEM_W-1:0] rd_data;

	obb_front #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.ITEM_W(ITEM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.a_centre(a_centre),
		.a_extent(a_extent),
		.a_axis_x(a_axis_x),
		.a_axis_y(a_axis_y),
		.a_axis_z(a_axis_z),
		.b_centre(b_centre),
		.b_extent(b_extent),
		.b_axis_x(b_axis_x),
		.b_axis_y(b_axis_y),
		.b_axis_z(b_axis_z),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	// back pipeline drains one entry every cycle
	obb_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(rd_vld),
		.rd_vld(rd_vld),
		.rd_data(rd_data)
	);

	obb_back #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.ITEM_W(ITEM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_vld(rd_vld),
		.item(rd_data),
		.done(done),
		.overlap(overlap)
	);
endmodule

/* src/obb_queue.sv */
// two-entry request queue between front and back
// depends on obb_pkg
module obb_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_vld,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PW = obb_pkg::QUEUE_PTR_W;

	logic [WIDTH-1:0] mem_q [obb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;

	assign full    = (count_q == (PW+1)'(obb_pkg::QUEUE_DEPTH));
	assign rd_vld  = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* src/obb_front.sv */
// front end: takes a box pair, unpacks it and forms the centre offset
// depends on obb_pkg
module obb_front #(
	parameter int COMPONENT_BITS = obb_pkg::COMPONENT_BITS,
	parameter int ITEM_W         = 27 * COMPONENT_BITS + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [obb_pkg::FIELD_W-1:0] a_centre,
	input  logic [obb_pkg::FIELD_W-1:0] a_extent,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_x,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_y,
	input  logic [obb_pkg::FIELD_W-1:0] a_axis_z,
	input  logic [obb_pkg::FIELD_W-1:0] b_centre,
	input  logic [obb_pkg::FIELD_W-1:0] b_extent,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_x,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_y,
	input  logic [obb_pkg::FIELD_W-1:0] b_axis_z,
	input  logic                        q_full,
	output logic                        push,
	output logic [ITEM_W-1:0]           push_data
);
	localparam int N      = COMPONENT_BITS;
	localparam int DW     = N + 1;
	localparam int OFF_EA = 3 * DW;
	localparam int OFF_EB = OFF_EA + 3 * N;
	localparam int OFF_AX = OFF_EB + 3 * N;
	localparam int OFF_BX = OFF_AX + 9 * N;

	logic              vld_q;
	logic [ITEM_W-1:0] item_q;
	logic [ITEM_W-1:0] item_d;
	logic              take;

	always_comb begin
		logic signed [N-1:0] ca, cb;
		item_d = '0;
		for (int c = 0; c < 3; c++) begin
			ca = a_centre[c*N +: N];
			cb = b_centre[c*N +: N];
			item_d[c*DW +: DW]          = DW'(cb) - DW'(ca);
			item_d[OFF_EA + c*N +: N]   = a_extent[c*N +: N];
			item_d[OFF_EB + c*N +: N]   = b_extent[c*N +: N];
			item_d[OFF_AX + c*N +: N]   = a_axis_x[c*N +: N];
			item_d[OFF_AX + (3+c)*N +: N] = a_axis_y[c*N +: N];
			item_d[OFF_AX + (6+c)*N +: N] = a_axis_z[c*N +: N];
			item_d[OFF_BX + c*N +: N]   = b_axis_x[c*N +: N];
			item_d[OFF_BX + (3+c)*N +: N] = b_axis_y[c*N +: N];
			item_d[OFF_BX + (6+c)*N +: N] = b_axis_z[c*N +: N];
		end
	end

	// stage register holds while the queue is full
	assign busy      = vld_q && q_full;
	assign take      = start && !busy;
	assign push      = vld_q && !q_full;
	assign push_data = item_q;

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!busy) begin
			vld_q <= start;
		end
	end
endmodule

/* src/obb_back.sv */
// back end: rotation, offset, products and the fifteen axis tests
// depends on obb_pkg
module obb_back #(
	parameter int COMPONENT_BITS = obb_pkg::COMPONENT_BITS,
	parameter int ITEM_W         = 27 * COMPONENT_BITS + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_vld,
	input  logic [ITEM_W-1:0] item,
	output logic              done,
	output logic              overlap
);
	localparam int N      = COMPONENT_BITS;
	localparam int F      = N - 2;
	localparam int DW     = N + 1;
	localparam int OFF_EA = 3 * DW;
	localparam int OFF_EB = OFF_EA + 3 * N;
	localparam int OFF_AX = OFF_EB + 3 * N;
	localparam int OFF_BX = OFF_AX + 9 * N;
	localparam int TW     = 2 * N + 2;  // t = d . Ai
	localparam int RW     = 2 * N + 1;  // r = Ai . Bk
	localparam int AW     = 2 * N;      // |r|
	localparam int H      = N + 1;      // split point for partial products
	localparam int PPW    = 2 * N + 4;
	localparam int CW     = 4 * N + 6;  // common compare width

	logic [5:0] vld_q;

	// unpack
	logic signed [DW-1:0] d_u  [3];
	logic signed [N-1:0]  ea_u [3];
	logic signed [N-1:0]  eb_u [3];
	logic signed [N-1:0]  ax_u [3][3];
	logic signed [N-1:0]  bx_u [3][3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d_u[c]  = item[c*DW +: DW];
			ea_u[c] = item[OFF_EA + c*N +: N];
			eb_u[c] = item[OFF_EB + c*N +: N];
			for (int i = 0; i < 3; i++) begin
				ax_u[i][c] = item[OFF_AX + (3*i+c)*N +: N];
				bx_u[i][c] = item[OFF_BX + (3*i+c)*N +: N];
			end
		end
	end

	// s1: component products
	logic signed [2*N:0]   dax_s1 [3][3];
	logic signed [2*N-1:0] abx_s1 [3][3][3];
	logic signed [N-1:0]   ea_s1 [3], eb_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ea_s1[i] <= ea_u[i];
			eb_s1[i] <= eb_u[i];
			for (int c = 0; c < 3; c++) begin
				dax_s1[i][c] <= (2*N+1)'(d_u[c]) * (2*N+1)'(ax_u[i][c]);
				for (int k = 0; k < 3; k++) begin
					abx_s1[i][k][c] <= (2*N)'(ax_u[i][c]) * (2*N)'(bx_u[k][c]);
				end
			end
		end
	end

	// s2: dot products
	logic signed [TW-1:0] t_s2 [3];
	logic signed [RW-1:0] r_s2 [3][3];
	logic [AW-1:0]        ar_s2 [3][3];
	logic signed [N-1:0]  ea_s2 [3], eb_s2 [3];

	always_ff @(posedge clk) begin
		logic signed [RW-1:0] rs;
		for (int i = 0; i < 3; i++) begin
			ea_s2[i] <= ea_s1[i];
			eb_s2[i] <= eb_s1[i];
			t_s2[i]  <= TW'(dax_s1[i][0]) + TW'(dax_s1[i][1]) + TW'(dax_s1[i][2]);
			for (int k = 0; k < 3; k++) begin
				rs = RW'(abx_s1[i][k][0]) + RW'(abx_s1[i][k][1]) + RW'(abx_s1[i][k][2]);
				r_s2[i][k]  <= rs;
				ar_s2[i][k] <= rs[RW-1] ? AW'(-rs) : AW'(rs);
			end
		end
	end

	// s3: partial products, tr = t[x]*r[y][k], ea = ea[x]*ar[y][k], eb = eb[x]*ar[y][k]
	logic signed [PPW-1:0] tr_hh_s3 [3][3][3], tr_hl_s3 [3][3][3];
	logic signed [PPW-1:0] tr_lh_s3 [3][3][3], tr_ll_s3 [3][3][3];
	logic signed [PPW-1:0] ea_h_s3 [3][3][3], ea_l_s3 [3][3][3];
	logic signed [PPW-1:0] eb_h_s3 [3][3][3], eb_l_s3 [3][3][3];
	logic signed [TW-1:0]  t_s3 [3];
	logic signed [N-1:0]   ea_s3 [3], eb_s3 [3];

	always_ff @(posedge clk) begin
		logic signed [TW-H-1:0] th;
		logic signed [H:0]      tl;
		logic signed [RW-H-1:0] rh;
		logic signed [H:0]      rl;
		logic signed [AW-H:0]   arh;
		logic signed [H:0]      arl;
		for (int x = 0; x < 3; x++) begin
			t_s3[x]  <= t_s2[x];
			ea_s3[x] <= ea_s2[x];
			eb_s3[x] <= eb_s2[x];
			th = t_s2[x][TW-1:H];
			tl = {1'b0, t_s2[x][H-1:0]};
			for (int y = 0; y < 3; y++) begin
				for (int k = 0; k < 3; k++) begin
					rh  = r_s2[y][k][RW-1:H];
					rl  = {1'b0, r_s2[y][k][H-1:0]};
					arh = {1'b0, ar_s2[y][k][AW-1:H]};
					arl = {1'b0, ar_s2[y][k][H-1:0]};
					tr_hh_s3[x][y][k] <= PPW'(th) * PPW'(rh);
					tr_hl_s3[x][y][k] <= PPW'(th) * PPW'(rl);
					tr_lh_s3[x][y][k] <= PPW'(tl) * PPW'(rh);
					tr_ll_s3[x][y][k] <= PPW'(tl) * PPW'(rl);
					ea_h_s3[x][y][k]  <= PPW'(ea_s2[x]) * PPW'(arh);
					ea_l_s3[x][y][k]  <= PPW'(ea_s2[x]) * PPW'(arl);
					eb_h_s3[x][y][k]  <= PPW'(eb_s2[x]) * PPW'(arh);
					eb_l_s3[x][y][k]  <= PPW'(eb_s2[x]) * PPW'(arl);
				end
			end
		end
	end

	// s4: full products
	logic signed [CW-1:0] tr_s4 [3][3][3], eap_s4 [3][3][3], ebp_s4 [3][3][3];
	logic signed [TW-1:0] t_s4 [3];
	logic signed [N-1:0]  ea_s4 [3], eb_s4 [3];

	always_ff @(posedge clk) begin
		for (int x = 0; x < 3; x++) begin
			t_s4[x]  <= t_s3[x];
			ea_s4[x] <= ea_s3[x];
			eb_s4[x] <= eb_s3[x];
			for (int y = 0; y < 3; y++) begin
				for (int k = 0; k < 3; k++) begin
					tr_s4[x][y][k] <= (CW'(tr_hh_s3[x][y][k]) <<< (2*H))
						+ ((CW'(tr_hl_s3[x][y][k]) + CW'(tr_lh_s3[x][y][k])) <<< H)
						+ CW'(tr_ll_s3[x][y][k]);
					eap_s4[x][y][k] <= (CW'(ea_h_s3[x][y][k]) <<< H) + CW'(ea_l_s3[x][y][k]);
					ebp_s4[x][y][k] <= (CW'(eb_h_s3[x][y][k]) <<< H) + CW'(eb_l_s3[x][y][k]);
				end
			end
		end
	end

	// s5: projected distance and radius sum for every axis
	// 0..2 A axes, 3..5 B axes, 6..14 cross axes
	logic signed [CW-1:0] proj_s5 [15], rad_s5 [15];

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] ra;
		int i1, i2, k1, k2;
		for (int i = 0; i < 3; i++) begin
			proj_s5[i] <= CW'(t_s4[i]) <<< F;
			rad_s5[i]  <= (CW'(ea_s4[i]) <<< (2*F))
				+ ebp_s4[0][i][0] + ebp_s4[1][i][1] + ebp_s4[2][i][2];
		end
		for (int k = 0; k < 3; k++) begin
			proj_s5[3+k] <= tr_s4[0][0][k] + tr_s4[1][1][k] + tr_s4[2][2][k];
			ra = eap_s4[0][0][k] + eap_s4[1][1][k] + eap_s4[2][2][k];
			rad_s5[3+k] <= (ra <<< F) + (CW'(eb_s4[k]) <<< (3*F));
		end
		for (int i = 0; i < 3; i++) begin
			i1 = (i == 2) ? 0 : i + 1;
			i2 = (i == 0) ? 2 : i - 1;
			for (int k = 0; k < 3; k++) begin
				k1 = (k == 2) ? 0 : k + 1;
				k2 = (k == 0) ? 2 : k - 1;
				proj_s5[6+3*i+k] <= tr_s4[i2][i1][k] - tr_s4[i1][i2][k];
				rad_s5[6+3*i+k]  <= (eap_s4[i1][i2][k] + eap_s4[i2][i1][k]
					+ ebp_s4[k1][i][k2] + ebp_s4[k2][i][k1]) <<< F;
			end
		end
	end

	// s6: strict compare, touching boxes overlap
	logic overlap_q;

	always_ff @(posedge clk) begin
		logic sep;
		logic signed [CW-1:0] p;
		sep = 1'b0;
		for (int a = 0; a < 15; a++) begin
			p = proj_s5[a][CW-1] ? -proj_s5[a] : proj_s5[a];
			if (p > rad_s5[a]) begin
				sep = 1'b1;
			end
		end
		overlap_q <= !sep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], item_vld};
		end
	end

	assign done    = vld_q[5];
	assign overlap = overlap_q;
endmodule
